// File: hdl/bdaf_pkg.sv
package bdaf_pkg;

  localparam int ValueWidth = 15;
  localparam int CountWidth = 3;
  localparam int PosWidth   = 8;
  localparam int CharWidth  = 7;

  // Restoring division steps: six for thousands, four each for hundreds and tens.
  // The thousands place reaches 32 for the largest input, so it needs six bits.
  localparam int NumSteps   = 14;
  localparam int StepWidth  = $clog2(NumSteps);
  localparam int ThouWidth  = 6;
  localparam int DigitWidth = 4;

  localparam logic [CharWidth-1:0] CharZero     = 7'd48;
  localparam logic [CharWidth-1:0] CharLetterA  = 7'd65;
  localparam logic [CharWidth-1:0] CharOverflow = 7'd56;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EMIT
  } state_t;

  // Weight subtracted at each step of the shared subtractor.
  function automatic logic [ValueWidth-1:0] step_weight(input logic [StepWidth-1:0] step);
    logic [ValueWidth-1:0] w;
    case (step)
      4'd0:    w = 15'd32000;
      4'd1:    w = 15'd16000;
      4'd2:    w = 15'd8000;
      4'd3:    w = 15'd4000;
      4'd4:    w = 15'd2000;
      4'd5:    w = 15'd1000;
      4'd6:    w = 15'd800;
      4'd7:    w = 15'd400;
      4'd8:    w = 15'd200;
      4'd9:    w = 15'd100;
      4'd10:   w = 15'd80;
      4'd11:   w = 15'd40;
      4'd12:   w = 15'd20;
      4'd13:   w = 15'd10;
      default: w = 15'd0;
    endcase
    return w;
  endfunction

  function automatic logic [CharWidth-1:0] digit_to_ascii(input logic [ThouWidth-1:0] d);
    logic [CharWidth-1:0] c;
    if (d <= ThouWidth'(9)) begin
      c = CharZero + CharWidth'(d);
    end else if (d <= ThouWidth'(15)) begin
      c = CharLetterA + CharWidth'(d - ThouWidth'(10));
    end else begin
      c = CharOverflow;
    end
    return c;
  endfunction

endpackage

// File: hdl/binary_to_decimal_ascii_formatter.sv
// Prints a 15-bit unsigned number as up to four ASCII decimal digits. Raise start
// while busy is low to hand over value, digit_count and start_position; busy then
// stays high until the last character has gone out. The number is split by one
// shared subtractor in 14 restoring steps, one per clock (six for the thousands,
// four each for hundreds and tens), after which one character is presented per
// clock with strobe high, most significant first, at consecutive positions that
// wrap at 256. Busy therefore stays high through all division steps and characters,
// and a new number is taken only once it has dropped; a digit_count other than 1 to
// 4 gives no characters after the 14 steps. Each character is valid for exactly one
// cycle and the receiver cannot stall it. A thousands value of 10 to 15 prints as
// 'A' to 'F', and anything above 15 as '8'.
module binary_to_decimal_ascii_formatter (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [bdaf_pkg::ValueWidth-1:0] value,
  input  logic [bdaf_pkg::CountWidth-1:0] digit_count,
  input  logic [bdaf_pkg::PosWidth-1:0]   start_position,
  output logic                           strobe,
  output logic [bdaf_pkg::CharWidth-1:0]  digit_char,
  output logic [bdaf_pkg::PosWidth-1:0]   position,
  output logic                           last
);
  import bdaf_pkg::*;

  state_t                state;
  state_t                state_next;
  logic [StepWidth-1:0]  step;
  logic [ValueWidth-1:0] rem;
  logic [NumSteps-1:0]   qbits;
  logic [1:0]            digit_idx;
  logic [PosWidth-1:0]   pos;
  logic                  count_ok;

  logic                  accept;
  logic                  last_step;
  logic [ValueWidth:0]   diff;
  logic                  fits;
  logic [ThouWidth-1:0]  cur_digit;

  assign accept    = start && !busy;
  assign last_step = (step == StepWidth'(NumSteps - 1));
  assign diff      = {1'b0, rem} - {1'b0, step_weight(step)};
  assign fits      = !diff[ValueWidth];

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (last_step) state_next = count_ok ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (digit_idx == 2'd3) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rem       <= value;
      step      <= '0;
      pos       <= start_position;
      count_ok  <= (digit_count >= 3'd1) && (digit_count <= 3'd4);
      // Index of the first digit to print: four digits start at the thousands.
      digit_idx <= 2'(3'd4 - digit_count);
    end else if (state == ST_DIVIDE) begin
      if (fits) rem <= diff[ValueWidth-1:0];
      qbits <= {qbits[NumSteps-2:0], fits};
      step  <= step + StepWidth'(1);
    end else if (state == ST_EMIT) begin
      digit_idx <= digit_idx + 2'd1;
      pos       <= pos + PosWidth'(1);
    end
  end

  // The quotient bits collect thousands, hundreds and tens in that order; the
  // remainder left after the last step is the ones digit.
  always_comb begin
    case (digit_idx)
      2'd0:    cur_digit = qbits[NumSteps-1 -: ThouWidth];
      2'd1:    cur_digit = ThouWidth'(qbits[2*DigitWidth-1 -: DigitWidth]);
      2'd2:    cur_digit = ThouWidth'(qbits[DigitWidth-1:0]);
      default: cur_digit = ThouWidth'(rem[DigitWidth-1:0]);
    endcase
  end

  always_comb begin
    busy       = (state != ST_IDLE);
    strobe     = (state == ST_EMIT);
    digit_char = digit_to_ascii(cur_digit);
    position   = pos;
    last       = (state == ST_EMIT) && (digit_idx == 2'd3);
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !strobe)
    else $error("accepted beat did not raise busy");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |=> !busy)
    else $error("block still busy after last character");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe && (position == PosWidth'($past(position) + 8'd1)))
    else $error("characters not at consecutive positions");

  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy)
    else $error("character emitted while idle");
`endif

endmodule

// File: test/bdaf_digit_checker.sv
`timescale 1ns / 100ps

module bdaf_digit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic [bdaf_pkg::ValueWidth-1:0] value,
  input  logic [bdaf_pkg::CountWidth-1:0] digit_count,
  input  logic [bdaf_pkg::PosWidth-1:0]   start_position,
  input  logic                            strobe,
  input  logic [bdaf_pkg::CharWidth-1:0]  digit_char,
  input  logic [bdaf_pkg::PosWidth-1:0]   position,
  input  logic                            last,
  output int                              mismatches,
  output int                              outstanding,
  output int                              chars_seen
);

  typedef struct packed {
    logic [bdaf_pkg::CharWidth-1:0] glyph;
    logic [bdaf_pkg::PosWidth-1:0]  pos;
    logic                           last;
  } char_beat_t;

  localparam int ReportLimit = 10;

  char_beat_t awaited_chars[$];

  function automatic logic [bdaf_pkg::CharWidth-1:0] glyph_of(input int unsigned place);
    if (place < 10) begin
      return bdaf_pkg::CharZero + bdaf_pkg::CharWidth'(place);
    end else if (place < 16) begin
      return bdaf_pkg::CharLetterA + bdaf_pkg::CharWidth'(place - 10);
    end
    return bdaf_pkg::CharOverflow;
  endfunction

  // Splits the number into thousands, hundreds, tens and ones and queues the
  // low digits, most significant first. The thousands place is left unbounded.
  task automatic queue_digits(input logic [bdaf_pkg::ValueWidth-1:0] num,
                              input logic [bdaf_pkg::CountWidth-1:0] count,
                              input logic [bdaf_pkg::PosWidth-1:0]   first_pos);
    int unsigned places [4];
    int unsigned rest;
    logic [bdaf_pkg::PosWidth-1:0] pos;
    char_beat_t beat;
    rest      = 32'(num);
    places[0] = rest / 1000;
    rest      = rest % 1000;
    places[1] = rest / 100;
    rest      = rest % 100;
    places[2] = rest / 10;
    places[3] = rest % 10;
    pos       = first_pos;
    if (count >= 1 && count <= 4) begin
      for (int k = 4 - int'(count); k < 4; k++) begin
        beat.glyph = glyph_of(places[k]);
        beat.pos   = pos;
        beat.last  = (k == 3);
        awaited_chars.push_back(beat);
        pos = pos + bdaf_pkg::PosWidth'(1);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    char_beat_t want;
    if (rst) begin
      awaited_chars.delete();
      mismatches <= 0;
      chars_seen <= 0;
    end else begin
      if (strobe) begin
        chars_seen <= chars_seen + 1;
        if (awaited_chars.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("[%0t] character 0x%02h at position %0d (last %b) with nothing awaited",
                     $realtime, digit_char, position, last);
          end
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_chars.pop_front();
          if (want.glyph !== digit_char || want.pos !== position || want.last !== last) begin
            if (mismatches < ReportLimit) begin
              $display("[%0t] beat mismatch: char 0x%02h/0x%02h pos %0d/%0d last %b/%b",
                       $realtime, want.glyph, digit_char, want.pos, position,
                       want.last, last);
              $display("        (expected/actual for each field)");
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      // A number accepted on this edge cannot produce a beat on the same edge.
      if (start && !busy) begin
        queue_digits(value, digit_count, start_position);
      end
    end
    outstanding <= awaited_chars.size();
  end

endmodule

// File: test/tb_binary_to_decimal_ascii_formatter.sv
`timescale 1ns / 100ps

module tb_binary_to_decimal_ascii_formatter;

  localparam int RandomNumbers = 230;
  localparam int CycleLimit    = 200000;
  localparam int SettleCycles  = 24;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic                            busy;
  logic [bdaf_pkg::ValueWidth-1:0] value = '0;
  logic [bdaf_pkg::CountWidth-1:0] digit_count = '0;
  logic [bdaf_pkg::PosWidth-1:0]   start_position = '0;
  logic                            strobe;
  logic [bdaf_pkg::CharWidth-1:0]  digit_char;
  logic [bdaf_pkg::PosWidth-1:0]   position;
  logic                            last;

  int mismatches;
  int outstanding;
  int chars_seen;
  int cycle_count  = 0;
  int numbers_sent = 0;
  int blank_sent   = 0;
  int burst_left   = 0;

  binary_to_decimal_ascii_formatter u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .value          (value),
    .digit_count    (digit_count),
    .start_position (start_position),
    .strobe         (strobe),
    .digit_char     (digit_char),
    .position       (position),
    .last           (last)
  );

  bdaf_digit_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .value          (value),
    .digit_count    (digit_count),
    .start_position (start_position),
    .strobe         (strobe),
    .digit_char     (digit_char),
    .position       (position),
    .last           (last),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .chars_seen     (chars_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Timed out after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Holds start until the block takes the number, then either carries straight
  // on with the burst or drops start for a random gap.
  task automatic send_number(input logic [bdaf_pkg::ValueWidth-1:0] num,
                             input logic [bdaf_pkg::CountWidth-1:0] count,
                             input logic [bdaf_pkg::PosWidth-1:0]   first_pos);
    int gap;
    start          <= 1'b1;
    value          <= num;
    digit_count    <= count;
    start_position <= first_pos;
    do @(posedge clk); while (busy);
    numbers_sent++;
    if (count == 0 || count > 4) begin
      blank_sent++;
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
    end
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [bdaf_pkg::ValueWidth-1:0] pick_value();
    case ($urandom_range(0, 3))
      0:       return bdaf_pkg::ValueWidth'($urandom_range(0, 32767));
      1:       return bdaf_pkg::ValueWidth'($urandom_range(0, 9999));
      2:       return bdaf_pkg::ValueWidth'($urandom_range(10000, 15999));
      default: return bdaf_pkg::ValueWidth'($urandom_range(0, 99));
    endcase
  endfunction

  function automatic logic [bdaf_pkg::CountWidth-1:0] pick_count();
    logic [bdaf_pkg::CountWidth-1:0] count;
    if ($urandom_range(0, 19) < 3) begin
      count = bdaf_pkg::CountWidth'($urandom_range(4, 7));
      if (count == 4) begin
        count = '0;
      end
    end else begin
      count = bdaf_pkg::CountWidth'($urandom_range(1, 4));
    end
    return count;
  endfunction

  function automatic logic [bdaf_pkg::PosWidth-1:0] pick_position();
    if ($urandom_range(0, 7) == 0) begin
      return bdaf_pkg::PosWidth'($urandom_range(252, 255));
    end
    return bdaf_pkg::PosWidth'($urandom_range(0, 255));
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, every digit count, letter and overflow thousands, wraps.
    send_number(15'd0,     3'd4, 8'd0);
    send_number(15'd32767, 3'd4, 8'd255);
    send_number(15'd9999,  3'd4, 8'd10);
    send_number(15'd10000, 3'd4, 8'd20);
    send_number(15'd15999, 3'd4, 8'd30);
    send_number(15'd16000, 3'd4, 8'd40);
    send_number(15'd12345, 3'd1, 8'd50);
    send_number(15'd12345, 3'd2, 8'd60);
    send_number(15'd12345, 3'd3, 8'd70);
    send_number(15'd12345, 3'd4, 8'd80);
    send_number(15'd1234,  3'd0, 8'd90);
    send_number(15'd1234,  3'd5, 8'd91);
    send_number(15'd1234,  3'd6, 8'd92);
    send_number(15'd1234,  3'd7, 8'd93);
    send_number(15'd987,   3'd4, 8'd254);
    send_number(15'd9,     3'd1, 8'd255);
    send_number(15'd1000,  3'd4, 8'd253);
    send_number(15'd999,   3'd3, 8'd128);
    send_number(15'd21845, 3'd4, 8'hAA);
    send_number(15'd10922, 3'd4, 8'h55);
    send_number(15'd10,    3'd2, 8'd0);
    wait_for_quiet();

    for (int n = 0; n < RandomNumbers; n++) begin
      send_number(pick_value(), pick_count(), pick_position());
      if (n == RandomNumbers / 2) begin
        wait_for_quiet();
      end
    end

    wait_for_quiet();
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d numbers, %0d of them with a digit count that prints nothing.",
             numbers_sent, blank_sent);
    $display("Compared %0d characters against the predicted digits.", chars_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches, %0d characters never arrived", mismatches, outstanding);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
